// File: hdl/nfa_pkg.sv
// Shared types, codes and defaults of the next-fit identifier allocator.
package nfa_pkg;

  localparam int NUM_IDS_DEF   = 256;
  localparam int WORD_BITS_DEF = 32;
  // map bits examined per cycle by the scan shift register
  localparam int DIGIT_BITS    = 8;

  localparam int ID_W = 9;
  localparam int ST_W = 2;
  localparam int TD_W = ((ID_W + 7) / 8) * 8;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } scan_stat_t;

endpackage

// File: hdl/next_fit_id_allocator_top.sv
// Next-fit identifier allocator: used-bit map memory, scan sequencer and result register.
// One item per request. After reset the map is cleared one word per cycle, all MAP_WORDS
// words (8 with the defaults), with in_tready low. An allocate reads map words starting
// at the word that holds last granted index plus one, wrapping once, and walks each word
// through a shift register DIGIT_BITS bits per cycle (DPW = WORD_BITS/DIGIT_BITS digits
// per word, 4 by default); each visit reads the word (S_ARD), loads it (S_ALD) and steps
// through its digits (S_ASH), and up to MAP_WORDS + 1 words are visited when the pool is
// nearly full or exhausted. A free splits id - 1 into word and bit with a bit-serial
// divider and then does one read-modify-write; an out-of-range id is answered without
// the divider. The result sits in an output register, and the next item is taken while
// it waits.
module next_fit_id_allocator_top #(
  parameter int NUM_IDS   = nfa_pkg::NUM_IDS_DEF,
  parameter int WORD_BITS = nfa_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [nfa_pkg::TD_W-1:0]  in_tdata,   // free_id [8:0], zero fill above
  input  logic                      in_tuser,   // func [0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [nfa_pkg::TD_W-1:0]  out_tdata,  // granted_id [8:0], zero fill above
  output logic [nfa_pkg::ST_W-1:0]  out_tuser   // status [1:0]
);

  localparam int ID_W       = nfa_pkg::ID_W;
  localparam int TD_W       = nfa_pkg::TD_W;
  localparam int IDX_W      = $clog2(NUM_IDS);
  localparam int MAP_WORDS  = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
  localparam int BIT_W      = $clog2(WORD_BITS > 1 ? WORD_BITS : 2);
  localparam int LAST_VALID = NUM_IDS - (MAP_WORDS - 1) * WORD_BITS;
  localparam int GW         = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;
  localparam int XW         = (IDX_W > ID_W) ? IDX_W : ID_W;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ARD,
    S_ALD,
    S_ASH,
    S_FDIV,
    S_FRD,
    S_FCHK,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [WA_W-1:0]         cur_word_r;
  logic [WA_W-1:0]         start_word_r;
  logic [BIT_W-1:0]        sel_bit_r;
  logic                    pass_r;
  logic [WA_W-1:0]         last_word_r;
  logic [BIT_W-1:0]        last_bit_r;
  nfa_pkg::status_t        res_status_r;
  logic [ID_W-1:0]         res_granted_r;
  logic                    out_tvalid_r;
  logic [TD_W-1:0]         out_tdata_r;
  logic [nfa_pkg::ST_W-1:0] out_tuser_r;

  logic [WORD_BITS-1:0]    map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]    rd_q_r;
  logic                    mem_we;
  logic                    mem_re;
  logic [WORD_BITS-1:0]    mem_wd;

  logic [WA_W-1:0]         start_word_nxt;
  logic [BIT_W-1:0]        start_bit_nxt;
  logic                    in_acc;
  logic [ID_W-1:0]         fid;
  logic                    bad_range;
  logic [XW-1:0]           fid_m1;
  logic                    div_done;
  logic [IDX_W-1:0]        div_quo;
  logic [BIT_W-1:0]        div_rem;
  nfa_pkg::scan_ctl_t      scan_ctl;
  nfa_pkg::scan_stat_t     scan_stat;
  logic [BIT_W-1:0]        hit_bit;
  logic [WORD_BITS-1:0]    scan_mask;
  logic [GW-1:0]           grant_full;
  logic                    free_bit;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fid       = in_tdata[ID_W-1:0];
  assign bad_range = (fid == '0) || (32'(fid) > 32'(NUM_IDS));
  assign fid_m1    = XW'(fid) - XW'(1);

  // next-fit start: one past the last index granted, wrapping at the pool end
  always_comb begin
    if (last_word_r == WA_W'(MAP_WORDS - 1) && last_bit_r == BIT_W'(LAST_VALID - 1)) begin
      start_word_nxt = '0;
      start_bit_nxt  = '0;
    end else if (last_bit_r == BIT_W'(WORD_BITS - 1)) begin
      start_word_nxt = last_word_r + WA_W'(1);
      start_bit_nxt  = '0;
    end else begin
      start_word_nxt = last_word_r;
      start_bit_nxt  = last_bit_r + BIT_W'(1);
    end
  end

  // hide bits below the start on the first visit and bits past the pool end
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      scan_mask[j] = (!pass_r && cur_word_r == start_word_r && j < int'(sel_bit_r)) ||
                     (cur_word_r == WA_W'(MAP_WORDS - 1) && j >= LAST_VALID);
    end
  end

  assign scan_ctl.load = (state_r == S_ALD);
  assign scan_ctl.step = (state_r == S_ASH) && !scan_stat.hit && !scan_stat.last;

  nfa_digit_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .word_in (rd_q_r),
    .mask_in (scan_mask),
    .stat    (scan_stat),
    .hit_bit (hit_bit)
  );

  nfa_idx_div #(
    .NUM_IDS   (NUM_IDS),
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && in_tuser == nfa_pkg::FN_FREE && !bad_range),
    .dividend (fid_m1[IDX_W-1:0]),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign grant_full = GW'(cur_word_r) * GW'(WORD_BITS) + GW'(hit_bit) + GW'(1);
  assign free_bit   = rd_q_r[sel_bit_r];

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wd = '0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_ARD, S_FRD: begin
        mem_re = 1'b1;
      end
      S_ASH: begin
        mem_we = scan_stat.hit;
        mem_wd = rd_q_r | (WORD_BITS'(1) << hit_bit);
      end
      S_FCHK: begin
        mem_we = free_bit;
        mem_wd = rd_q_r & ~(WORD_BITS'(1) << sel_bit_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[cur_word_r] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= map_mem[cur_word_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cur_word_r   <= '0;
      last_word_r  <= '0;
      last_bit_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // a waiting result that leaves while the next one is ready is replaced in S_DONE
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (cur_word_r == WA_W'(MAP_WORDS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            cur_word_r <= cur_word_r + WA_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_granted_r <= '0;
            if (in_tuser == nfa_pkg::FN_ALLOC) begin
              cur_word_r   <= start_word_nxt;
              start_word_r <= start_word_nxt;
              sel_bit_r    <= start_bit_nxt;
              pass_r       <= 1'b0;
              state_r      <= S_ARD;
            end else if (bad_range) begin
              res_status_r <= nfa_pkg::ST_BAD_FREE;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_FDIV;
            end
          end
        end
        S_ARD: begin
          state_r <= S_ALD;
        end
        S_ALD: begin
          state_r <= S_ASH;
        end
        S_ASH: begin
          if (scan_stat.hit) begin
            last_word_r   <= cur_word_r;
            last_bit_r    <= hit_bit;
            res_granted_r <= grant_full[ID_W-1:0];
            res_status_r  <= nfa_pkg::ST_OK;
            state_r       <= S_DONE;
          end else if (scan_stat.last) begin
            // second pass ends on the start word: every id is taken
            if (pass_r && cur_word_r == start_word_r) begin
              res_status_r <= nfa_pkg::ST_EXHAUSTED;
              state_r      <= S_DONE;
            end else if (!pass_r && cur_word_r == WA_W'(MAP_WORDS - 1)) begin
              pass_r     <= 1'b1;
              cur_word_r <= '0;
              state_r    <= S_ARD;
            end else begin
              cur_word_r <= cur_word_r + WA_W'(1);
              state_r    <= S_ARD;
            end
          end
        end
        S_FDIV: begin
          if (div_done) begin
            cur_word_r <= div_quo[WA_W-1:0];
            sel_bit_r  <= div_rem;
            state_r    <= S_FRD;
          end
        end
        S_FRD: begin
          state_r <= S_FCHK;
        end
        S_FCHK: begin
          res_status_r <= free_bit ? nfa_pkg::ST_OK : nfa_pkg::ST_BAD_FREE;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= TD_W'(res_granted_r);
            out_tuser_r  <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: hdl/nfa_idx_div.sv
// Bit-serial restoring divider that splits an index into map word and bit.
module nfa_idx_div #(
  parameter int NUM_IDS   = nfa_pkg::NUM_IDS_DEF,
  parameter int WORD_BITS = nfa_pkg::WORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [$clog2(NUM_IDS)-1:0]                   dividend,
  output logic                                         done,
  output logic [$clog2(NUM_IDS)-1:0]                   quo,
  output logic [$clog2(WORD_BITS > 1 ? WORD_BITS : 2)-1:0] rem
);

  localparam int IDX_W = $clog2(NUM_IDS);
  localparam int BIT_W = $clog2(WORD_BITS > 1 ? WORD_BITS : 2);
  localparam int CNT_W = $clog2(IDX_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] dvd_r;
  logic [IDX_W-1:0] quo_r;
  logic [BIT_W-1:0] rem_r;
  logic [BIT_W:0]   trial;
  logic             qbit;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, dvd_r[IDX_W-1]};
  assign qbit  = (trial >= (BIT_W + 1)'(WORD_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(IDX_W);
        dvd_r  <= dividend;
        quo_r  <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        quo_r <= IDX_W'({quo_r, qbit});
        if (qbit) begin
          rem_r <= BIT_W'(trial - (BIT_W + 1)'(WORD_BITS));
        end else begin
          rem_r <= trial[BIT_W-1:0];
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: hdl/nfa_digit_scan.sv
// Digit-serial free-bit search over one map word held in a shift register.
module nfa_digit_scan #(
  parameter int WORD_BITS = nfa_pkg::WORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  nfa_pkg::scan_ctl_t                           ctl,
  input  logic [WORD_BITS-1:0]                         word_in,
  input  logic [WORD_BITS-1:0]                         mask_in,
  output nfa_pkg::scan_stat_t                          stat,
  output logic [$clog2(WORD_BITS > 1 ? WORD_BITS : 2)-1:0] hit_bit
);

  localparam int BIT_W = $clog2(WORD_BITS > 1 ? WORD_BITS : 2);
  localparam int DIG   = (WORD_BITS < nfa_pkg::DIGIT_BITS) ? WORD_BITS : nfa_pkg::DIGIT_BITS;
  localparam int DPW   = (WORD_BITS + DIG - 1) / DIG;
  localparam int PW    = DPW * DIG;
  localparam int DC_W  = $clog2(DPW > 1 ? DPW : 2);
  localparam int DP_W  = $clog2(DIG > 1 ? DIG : 2);

  logic [PW-1:0]   sh_r;
  logic [DC_W-1:0] dcnt_r;
  logic [PW-1:0]   padded;
  logic [DIG-1:0]  low;
  logic [DP_W-1:0] pos;

  // padding and masked bits read as used, so they are never picked
  always_comb begin
    padded                 = '1;
    padded[WORD_BITS-1:0]  = word_in | mask_in;
  end

  assign low = sh_r[DIG-1:0];

  always_comb begin
    pos = '0;
    for (int k = DIG - 1; k >= 0; k--) begin
      if (!low[k]) begin
        pos = DP_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (ctl.load) begin
      sh_r   <= padded;
      dcnt_r <= '0;
    end else if (ctl.step) begin
      sh_r   <= PW'({{DIG{1'b1}}, sh_r} >> DIG);
      dcnt_r <= dcnt_r + DC_W'(1);
    end
  end

  assign stat.hit  = ~&low;
  assign stat.last = (dcnt_r == DC_W'(DPW - 1));
  assign hit_bit   = BIT_W'(int'(dcnt_r) * DIG + int'(pos));

endmodule

// File: hdl/nfa_checker.sv
// Port-level checks of the identifier allocator, bound to its top level.
module nfa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [nfa_pkg::TD_W-1:0]  in_tdata,
  input logic                      in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [nfa_pkg::TD_W-1:0]  out_tdata,
  input logic [nfa_pkg::ST_W-1:0]  out_tuser
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // count items taken in but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result item without an accepted request");

  a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("request taken while two are outstanding");

  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != nfa_pkg::ST_OK |-> out_tdata == '0)
    else $error("identifier reported on a failed request");

endmodule

bind next_fit_id_allocator_top nfa_checker u_nfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
